// ----- rtl/cbfe_pkg.sv -----
// Shared types and constants for the complemented byte frame encoder.
package cbfe_pkg;

  localparam logic [7:0] PreambleA = 8'h55;
  localparam logic [7:0] PreambleB = 8'hFF;
  localparam logic [7:0] PreambleC = 8'h00;

  // One classified message byte as it waits in the queue.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_command;
    logic       is_last;
    logic [7:0] sum;
  } cbfe_item_t;

  // Byte slot that the back end emits next for the head item.
  typedef enum logic [2:0] {
    ST_FIRST,
    ST_PRE_B,
    ST_PRE_C,
    ST_DATA,
    ST_COMP,
    ST_SUM,
    ST_SUMC
  } cbfe_state_e;

  // Queue status seen by the front end and the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } cbfe_q_stat_t;

endpackage

// ----- rtl/cbfe_front.sv -----
// Front end: accepts message bytes, keeps the running sum and queues items.
module cbfe_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,
  input  logic                s_axis_tuser,
  input  logic                s_axis_tlast,
  input  cbfe_pkg::cbfe_q_stat_t q_stat_i,
  output logic                push_o,
  output cbfe_pkg::cbfe_item_t push_item_o
);
  import cbfe_pkg::*;

  logic [7:0] sum_q, sum_d;

  assign s_axis_tready = !q_stat_i.full;
  assign push_o        = s_axis_tvalid && s_axis_tready;

  // A command restarts the sum; a parameter adds into it modulo 256.
  assign sum_d = s_axis_tuser ? s_axis_tdata : 8'(sum_q + s_axis_tdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (push_o) begin
      sum_q <= sum_d;
    end
  end

  always_comb begin
    push_item_o.data_byte  = s_axis_tdata;
    push_item_o.is_command = s_axis_tuser;
    push_item_o.is_last    = s_axis_tlast;
    push_item_o.sum        = sum_d;
  end

endmodule

// ----- rtl/cbfe_queue.sv -----
// Small register queue between the front end and the back end.
module cbfe_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cbfe_pkg::cbfe_item_t push_item_i,
  input  logic                pop_i,
  output cbfe_pkg::cbfe_item_t head_item_o,
  output cbfe_pkg::cbfe_q_stat_t stat_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);
  import cbfe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cbfe_item_t          mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign head_item_o  = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign count_o      = cnt_q;

endmodule

// ----- rtl/cbfe_back.sv -----
// Back end: walks the byte slots of the head item and drives the output register.
module cbfe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cbfe_pkg::cbfe_item_t head_item_i,
  input  logic                head_valid_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,
  output logic                m_axis_tlast
);
  import cbfe_pkg::*;

  cbfe_state_e state_q, state_d;
  logic        load;
  logic [7:0]  byte_val;
  logic        byte_end;
  logic        tvalid_q;
  logic [7:0]  tdata_q;
  logic        tlast_q;

  // The output register takes a new beat when an item waits and the register is empty or being drained.
  assign load = head_valid_i && (!tvalid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    if (load) begin
      unique case (state_q)
        ST_FIRST: state_d = head_item_i.is_command ? ST_PRE_B : ST_COMP;
        ST_PRE_B: state_d = ST_PRE_C;
        ST_PRE_C: state_d = ST_DATA;
        ST_DATA:  state_d = ST_COMP;
        ST_COMP:  state_d = head_item_i.is_last ? ST_SUM : ST_FIRST;
        ST_SUM:   state_d = ST_SUMC;
        ST_SUMC:  state_d = ST_FIRST;
        default:  state_d = ST_FIRST;
      endcase
    end
  end

  always_comb begin
    byte_end = 1'b0;
    pop_o    = 1'b0;
    unique case (state_q)
      ST_FIRST: byte_val = head_item_i.is_command ? PreambleA : head_item_i.data_byte;
      ST_PRE_B: byte_val = PreambleB;
      ST_PRE_C: byte_val = PreambleC;
      ST_DATA:  byte_val = head_item_i.data_byte;
      ST_COMP: begin
        byte_val = ~head_item_i.data_byte;
        pop_o    = load && !head_item_i.is_last;
      end
      ST_SUM:   byte_val = head_item_i.sum;
      ST_SUMC: begin
        byte_val = ~head_item_i.sum;
        byte_end = 1'b1;
        pop_o    = load;
      end
      default:  byte_val = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_FIRST;
      tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tdata_q <= byte_val;
      tlast_q <= byte_end;
    end
  end

  assign m_axis_tvalid = tvalid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tlast  = tlast_q;

endmodule

// ----- rtl/complemented_byte_frame_encoder_unit.sv -----
// Top level of the complemented byte frame encoder with sum checksum.
//
//  Channel   Dir  tdata (low bit up)   tuser        tlast
//  s_axis    in   data_byte[7:0]       is_command   is_last
//  m_axis    out  out_byte[7:0]        (none)       frame_end
//
// One beat leaves the single output register per cycle unless the receiver
// stalls or the queue is empty; a parameter byte takes two beats, a parameter
// marked last four, a command five and a command marked last seven.
// The front end accepts a byte in the cycle it arrives as long as the queue
// has room; the queue lets input and output stall independently.
// Reset clears the running sum, the queue pointers and the output valid.
module complemented_byte_frame_encoder_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] is_command
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast
);
  import cbfe_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic          push, pop;
  cbfe_item_t    push_item, head_item;
  cbfe_q_stat_t  q_stat;
  logic [CntW-1:0] q_count;

  // The front end classifies each byte and folds it into the running sum, so
  // every queued item already carries the checksum valid after that byte.
  cbfe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  cbfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_item_o (head_item),
    .stat_o      (q_stat),
    .count_o     (q_count)
  );

  // The back end expands the head item into preamble (commands only), byte,
  // complement and optional checksum pair, one beat per cycle unless stalled.
  cbfe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_item_i   (head_item),
    .head_valid_i  (!q_stat.empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (q_count != CntW'(QueueDepth)))
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (q_count != '0))
    else $error("queue read while empty");

  a_push_fills_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (q_count != '0))
    else $error("accepted byte missing from queue");
`endif

endmodule
